[src/bmh_pkg.sv]
// ----------------------------------------------------------------------------
// bmh_pkg
// shared types and codes for the binary min-heap engine
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 11;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [1:0]              status_t;
  typedef logic [COUNT_W-1:0]      count_out_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

[src/bmh_if.sv]
// ----------------------------------------------------------------------------
// bmh_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface bmh_in_if import bmh_pkg::*;;
  logic valid;
  logic ready;
  logic opcode;
  key_t key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

interface bmh_out_if import bmh_pkg::*;;
  logic       valid;
  logic       ready;
  status_t    status;
  key_t       removed_key;
  key_t       min_key;
  count_out_t entry_count;
  logic       heap_empty;

  modport source (output valid, output status, output removed_key, output min_key,
                  output entry_count, output heap_empty, input ready);
  modport sink   (input valid, input status, input removed_key, input min_key,
                  input entry_count, input heap_empty, output ready);
endinterface

[src/bmh_store.sv]
// ----------------------------------------------------------------------------
// bmh_store
// heap array: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bmh_store import bmh_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  key_t          wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output key_t          rd_data_a,
  output key_t          rd_data_b
);

  key_t mem_r [CAPACITY];
  key_t rd_data_a_r;
  key_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a_r <= mem_r[rd_addr_a];
    rd_data_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

[src/bmh_ctrl.sv]
// ----------------------------------------------------------------------------
// bmh_ctrl
// sift sequencer with a shared key comparator, a child-select comparator, root cache and output register
// ----------------------------------------------------------------------------
module bmh_ctrl import bmh_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int CW       = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  input  key_t          in_key,
  output logic          out_valid,
  input  logic          out_ready,
  output status_t       out_status,
  output key_t          out_removed_key,
  output key_t          out_min_key,
  output count_out_t    out_entry_count,
  output logic          out_heap_empty,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output key_t          wr_data,
  output logic [AW-1:0] rd_addr_a,
  output logic [AW-1:0] rd_addr_b,
  input  key_t          rd_data_a,
  input  key_t          rd_data_b
);

  localparam int LW = AW + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_UP       = 3'd1;
  localparam logic [2:0] S_UP_LAST  = 3'd2;
  localparam logic [2:0] S_DN_LOAD  = 3'd3;
  localparam logic [2:0] S_DN_ISSUE = 3'd4;
  localparam logic [2:0] S_DN_CMP   = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  key_t          key_r, key_nxt;
  key_t          root_r, root_nxt;
  status_t       status_r, status_nxt;
  key_t          removed_r, removed_nxt;
  logic          right_ok_r, right_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  key_t          out_removed_r;
  key_t          out_min_r;
  count_out_t    out_count_r;
  logic          out_empty_r;
  logic          out_load;

  logic [AW-1:0] parent;
  logic [AW-1:0] new_parent;
  logic [LW-1:0] left_w;
  logic [LW-1:0] right_w;
  logic [LW-1:0] count_w;
  logic          pick_right;
  key_t          pick_val;
  logic [AW-1:0] pick_addr;
  key_t          cmp_a;
  key_t          cmp_b;
  logic          cmp_less;

  assign parent     = (pos_r - 1'b1) >> 1;
  assign new_parent = (count_r[AW-1:0] - 1'b1) >> 1;
  assign left_w     = {1'b0, pos_r, 1'b1};
  assign right_w    = left_w + 1'b1;
  assign count_w    = LW'(count_r);
  assign pick_right = right_ok_r && (rd_data_b < rd_data_a);
  assign pick_val   = pick_right ? rd_data_b : rd_data_a;
  assign pick_addr  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

  // shared comparator
  always_comb begin
    if (state_r == S_UP) begin
      cmp_a = key_r;
      cmp_b = rd_data_a;
    end else begin
      cmp_a = pick_val;
      cmp_b = key_r;
    end
  end
  assign cmp_less = cmp_a < cmp_b;

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    status_nxt   = status_r;
    removed_nxt  = removed_r;
    right_ok_nxt = right_ok_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = key_r;
    rd_addr_a    = parent;
    rd_addr_b    = parent;
    case (state_r)
      S_IDLE: begin
        if (in_opcode == OP_INSERT) begin
          rd_addr_a = new_parent;
        end else begin
          rd_addr_a = count_r[AW-1:0] - 1'b1;
        end
        if (in_valid) begin
          status_nxt  = ST_DONE;
          removed_nxt = '0;
          key_nxt     = in_key;
          if (in_opcode == OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
              if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_key;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              removed_nxt = root_r;
              count_nxt   = count_r - 1'b1;
              if (count_r == CW'(1)) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_DN_LOAD;
              end
            end
          end
        end
      end
      S_UP: begin
        if (cmp_less) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_a;
          pos_nxt   = parent;
          rd_addr_a = (parent - 1'b1) >> 1;
          if (parent == '0) begin
            state_nxt = S_UP_LAST;
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_UP_LAST: begin
        wr_en     = 1'b1;
        state_nxt = S_FIN;
      end
      S_DN_LOAD: begin
        key_nxt   = rd_data_a;
        pos_nxt   = '0;
        state_nxt = S_DN_ISSUE;
      end
      S_DN_ISSUE: begin
        rd_addr_a = left_w[AW-1:0];
        rd_addr_b = right_w[AW-1:0];
        if (left_w >= count_w) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          right_ok_nxt = right_w < count_w;
          state_nxt    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_less) begin
          wr_data   = pick_val;
          pos_nxt   = pick_addr;
          state_nxt = S_DN_ISSUE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // root cache follows every write to the top slot
  always_comb begin
    root_nxt = root_r;
    if (wr_en && wr_addr == '0) begin
      root_nxt = wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    root_r     <= root_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    right_ok_r <= right_ok_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_min_r     <= (count_r == '0) ? key_t'(0) : root_r;
      out_count_r   <= COUNT_W'(count_r);
      out_empty_r   <= (count_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_removed_key = out_removed_r;
  assign out_min_key     = out_min_r;
  assign out_entry_count = out_count_r;
  assign out_heap_empty  = out_empty_r;

endmodule

[src/binary_min_heap_engine.sv]
// insert: sifts the new key up L levels, L = levels climbed (at most log2 CAPACITY)
// remove: sifts the last key down from the root, reading both children per level through the two-port heap memory
// rejected items, insert into an empty heap and removal of the last key go straight to the result state
// ready only when idle, so a new item is taken only once the last result is in the output register
// a waiting result sits in the output register while the next item is taken
// synchronous active-low reset empties the heap; the store itself is not cleared
// ----------------------------------------------------------------------------
// binary_min_heap_engine
// binary min-heap priority queue of signed keys with insert and remove-min
// ----------------------------------------------------------------------------
module binary_min_heap_engine import bmh_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  bmh_in_if.sink   in_ch,
  bmh_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  key_t          wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  key_t          rd_data_a;
  key_t          rd_data_b;

  bmh_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_opcode       (in_ch.opcode),
    .in_key          (in_ch.key_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_removed_key (out_ch.removed_key),
    .out_min_key     (out_ch.min_key),
    .out_entry_count (out_ch.entry_count),
    .out_heap_empty  (out_ch.heap_empty),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b)
  );

  bmh_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

[tb/binary_min_heap_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_engine_tb
// Self-checking bench for the min-heap engine. Request items go in on a
// valid/ready channel and result items come back on another, both with random
// gaps. A shadow heap inside a small scoreboard predicts each result item. The
// run covers edge keys, equal keys and rejected requests, a burst of inserts
// and a drain past empty, and then phases of random requests, some balanced and
// some with a bias towards inserts or removals.
// ----------------------------------------------------------------------------
module binary_min_heap_engine_tb;
  import bmh_pkg::*;

  localparam int HEAP_CAP    = 1024;
  localparam int BURST_LEN   = 48;
  localparam int RANDOM_REQS = 280;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    status_t    status;
    key_t       removed_key;
    key_t       min_key;
    count_out_t entry_count;
    logic       heap_empty;
  } heap_result_t;

  class heap_order_tracker;
    key_t         keys [HEAP_CAP];
    int           fill;
    heap_result_t due_results [$];
    int           mismatch_count;

    function new();
      fill           = 0;
      mismatch_count = 0;
    endfunction

    function void swap_keys(int a, int b);
      key_t t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    function void accept_request(logic op, key_t key);
      heap_result_t r;
      int           pos;
      int           up;
      int           left;
      int           pick;
      r.status      = ST_DONE;
      r.removed_key = '0;
      r.min_key     = '0;
      if (op == OP_INSERT) begin
        if (fill >= HEAP_CAP) begin
          r.status = ST_FULL;
        end else begin
          keys[fill] = key;
          pos = fill;
          fill++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(keys[pos] < keys[up])) break;
            swap_keys(pos, up);
            pos = up;
          end
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_key = keys[0];
          fill--;
          if (fill > 0) begin
            keys[0] = keys[fill];
            pos = 0;
            forever begin
              left = 2 * pos + 1;
              if (left >= fill) break;
              pick = left;
              if (left + 1 < fill && keys[left + 1] < keys[left]) pick = left + 1;
              if (!(keys[pick] < keys[pos])) break;
              swap_keys(pos, pick);
              pos = pick;
            end
          end
        end
      end
      if (fill > 0) r.min_key = keys[0];
      r.entry_count = count_out_t'(fill);
      r.heap_empty  = (fill == 0);
      due_results = {due_results, r};
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (due_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: status %0d removed %0d min %0d count %0d empty %0d",
                   got.status, got.removed_key, got.min_key, got.entry_count, got.heap_empty);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.removed_key !== want.removed_key ||
          got.min_key !== want.min_key || got.entry_count !== want.entry_count ||
          got.heap_empty !== want.heap_empty) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected status %0d removed %0d min %0d count %0d empty %0d",
                   want.status, want.removed_key, want.min_key, want.entry_count,
                   want.heap_empty);
          $display("          actual   status %0d removed %0d min %0d count %0d empty %0d",
                   got.status, got.removed_key, got.min_key, got.entry_count,
                   got.heap_empty);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bmh_in_if  in_ch ();
  bmh_out_if out_ch ();

  heap_order_tracker tracker = new();

  bit send_quiet;
  bit recv_quiet  = 1'b0;
  int stall_left  = 0;
  int cycle_count = 0;

  binary_min_heap_engine #(.CAPACITY(HEAP_CAP)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 5))
      0, 1: return key_t'(int'($urandom_range(0, 15)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0:       return key_t'(32'h8000_0000);
          1:       return key_t'(32'h7fff_ffff);
          2:       return key_t'(32'h0000_0000);
          default: return key_t'(32'hffff_ffff);
        endcase
      end
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input key_t key);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key_in <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.accept_request(op, key);
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_ch.valid  <= 1'b0;
      in_ch.opcode <= 1'($urandom);
      in_ch.key_in <= key_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every result item is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_sink
    heap_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.removed_key = out_ch.removed_key;
      got.min_key     = out_ch.min_key;
      got.entry_count = out_ch.entry_count;
      got.heap_empty  = out_ch.heap_empty;
      tracker.check_result(got);
    end
    if (cycle_count % 256 == 0 && $urandom_range(0, 9) < 3) recv_quiet = !recv_quiet;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap(recv_quiet);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int   sent;
    int   len;
    int   ins_pct;
    logic op;
    send_quiet   = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.key_in = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // edge keys, equal keys, removal on an empty heap
    send_item(OP_REMOVE, '0);
    send_item(OP_INSERT, key_t'(32'h7fff_ffff));
    send_item(OP_INSERT, key_t'(32'h8000_0000));
    send_item(OP_INSERT, key_t'(32'h0000_0000));
    send_item(OP_INSERT, key_t'(32'hffff_ffff));
    send_item(OP_INSERT, key_t'(32'h0000_0001));
    send_item(OP_INSERT, key_t'(32'h5555_5555));
    send_item(OP_INSERT, key_t'(32'haaaa_aaaa));
    repeat (3) send_item(OP_INSERT, key_t'(5));
    repeat (11) send_item(OP_REMOVE, key_t'($urandom));
    wait_drained();

    // burst of inserts, then drain past empty
    for (int i = 0; i < BURST_LEN; i++) send_item(OP_INSERT, pick_key());
    for (int i = 0; i < BURST_LEN + 1; i++) send_item(OP_REMOVE, key_t'($urandom));
    wait_drained();

    sent = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 15;
        1:       ins_pct = 50;
        default: ins_pct = 80;
      endcase
      send_quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 60);
      repeat (len) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_item(op, pick_key());
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bmh_pkg.sv
src/bmh_if.sv
src/bmh_store.sv
src/bmh_ctrl.sv
src/binary_min_heap_engine.sv
tb/binary_min_heap_engine_tb.sv
